/* rtl/arpg_pkg.sv */
// Shared types, constants and byte helpers for the ARP gateway responder.
`timescale 1ns / 1ps
`default_nettype none

package arpg_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN   = 42;
  localparam int unsigned POS_W       = 6;
  localparam logic [POS_W-1:0] POS_FRAME_LEN = 6'd42;
  localparam logic [POS_W-1:0] POS_LAST_REQ  = 6'd41;
  localparam logic [POS_W-1:0] POS_HDR_START = 6'd12;
  localparam logic [POS_W-1:0] POS_SHA_START = 6'd22;
  localparam logic [POS_W-1:0] POS_SPA_START = 6'd28;
  localparam logic [POS_W-1:0] POS_THA_START = 6'd32;
  localparam logic [POS_W-1:0] POS_TPA_START = 6'd38;
  localparam logic [POS_W-1:0] POS_SRC_START = 6'd6;
  localparam logic [POS_W-1:0] POS_OPCODE_LO = 6'd21;

  // ARP reply opcode low byte
  localparam logic [7:0] OPCODE_REPLY = 8'h02;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONDER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP       = 2'd2;
  localparam int unsigned CFG_DATA_W = 48;

  typedef struct packed {
    logic        responder_enable;
    logic [47:0] local_mac;
    logic [31:0] gateway_ip;
  } arpg_cfg_t;

  // Reply launch request from parser to transmitter
  typedef struct packed {
    logic        valid;
    logic [47:0] requester_mac;
    logic [31:0] requester_ip;
  } arpg_trig_t;

  // Expected ARP header bytes, ethertype through opcode
  function automatic logic [7:0] hdr_expect(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'h08;
      4'd1:    b = 8'h06;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h08;
      4'd5:    b = 8'h00;
      4'd6:    b = 8'h06;
      4'd7:    b = 8'h04;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte i of a MAC, most significant first
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte i of an IPv4 address, most significant first
  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  // Reply frame byte at position p
  function automatic logic [7:0] reply_at(input logic [POS_W-1:0] p,
                                          input logic [47:0] req_mac,
                                          input logic [31:0] req_ip,
                                          input logic [47:0] lmac,
                                          input logic [31:0] gw_ip);
    logic [7:0] b;
    if (p < POS_SRC_START) begin
      b = mac_byte(req_mac, 3'(p));
    end else if (p < POS_HDR_START) begin
      b = mac_byte(lmac, 3'(p - POS_SRC_START));
    end else if (p < POS_OPCODE_LO) begin
      b = hdr_expect(4'(p - POS_HDR_START));
    end else if (p == POS_OPCODE_LO) begin
      b = OPCODE_REPLY;
    end else if (p < POS_SPA_START) begin
      b = mac_byte(lmac, 3'(p - POS_SHA_START));
    end else if (p < POS_THA_START) begin
      b = ip_byte(gw_ip, 2'(p - POS_SPA_START));
    end else if (p < POS_TPA_START) begin
      b = mac_byte(req_mac, 3'(p - POS_THA_START));
    end else begin
      b = ip_byte(req_ip, 2'(p - POS_TPA_START));
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/arpg_if.sv */
// Valid/ready channel interfaces for frame bytes, reply bytes and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface arpg_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;
  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface arpg_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;
  modport source (output valid, output reply_byte, output reply_last, input ready);
  modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

interface arpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/arpg_cfg_regs.sv */
// Configuration register file: enable, local MAC and gateway IP.
`timescale 1ns / 1ps
`default_nettype none

module arpg_cfg_regs
  import arpg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output arpg_cfg_t                  cfg
);

  arpg_cfg_t cfg_r;
  arpg_cfg_t cfg_nxt;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_RESPONDER_ENABLE: cfg_nxt.responder_enable = wr_data[0];
        REG_LOCAL_MAC:        cfg_nxt.local_mac        = wr_data[47:0];
        REG_GATEWAY_IP:       cfg_nxt.gateway_ip       = wr_data[31:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/arpg_parser.sv */
// Receive-side parser: byte position, header checks and sender address capture.
`timescale 1ns / 1ps
`default_nettype none

module arpg_parser
  import arpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire logic       rx_last,
  input  arpg_cfg_t       cfg,
  output logic            near_end,
  output arpg_trig_t      trig
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [47:0]      mac_r, mac_nxt;
  logic [31:0]      ip_r, ip_nxt;
  logic             fire;

  // Check or capture the byte at the current position
  always_comb begin
    pos_nxt    = pos_r;
    hdr_ok_nxt = hdr_ok_r;
    mac_nxt    = mac_r;
    ip_nxt     = ip_r;
    fire       = 1'b0;
    if (accept) begin
      if (pos_r < POS_FRAME_LEN) begin
        if (pos_r >= POS_HDR_START && pos_r < POS_SHA_START) begin
          if (rx_byte != hdr_expect(4'(pos_r - POS_HDR_START))) hdr_ok_nxt = 1'b0;
        end else if (pos_r >= POS_SHA_START && pos_r < POS_SPA_START) begin
          mac_nxt = {mac_r[39:0], rx_byte};
        end else if (pos_r >= POS_SPA_START && pos_r < POS_THA_START) begin
          ip_nxt = {ip_r[23:0], rx_byte};
        end else if (pos_r >= POS_TPA_START) begin
          if (rx_byte != ip_byte(cfg.gateway_ip, 2'(pos_r - POS_TPA_START))) begin
            hdr_ok_nxt = 1'b0;
          end
        end
        pos_nxt = pos_r + 6'd1;
      end
      // End of frame: launch a reply when long enough, matching and enabled, then rearm
      if (rx_last) begin
        fire       = (pos_nxt >= POS_FRAME_LEN) && hdr_ok_nxt && cfg.responder_enable;
        pos_nxt    = '0;
        hdr_ok_nxt = 1'b1;
      end
    end
  end

  // Requester fields are complete before the last request byte can fire
  assign trig = '{valid: fire, requester_mac: mac_r, requester_ip: ip_r};

  // A request at this position or later may launch a reply
  assign near_end = (pos_r >= POS_LAST_REQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_ok_r <= 1'b1;
    end else begin
      pos_r    <= pos_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r <= mac_nxt;
    ip_r  <= ip_nxt;
  end

endmodule

`default_nettype wire

/* rtl/arpg_reply_tx.sv */
// Reply transmitter: snapshot of requester fields, byte counter and output register.
`timescale 1ns / 1ps
`default_nettype none

module arpg_reply_tx
  import arpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  arpg_trig_t      trig,
  input  arpg_cfg_t       cfg,
  output logic            busy,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [47:0]      snap_mac_r;
  logic [31:0]      snap_ip_r;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             olast_r, olast_nxt;
  logic             advance;

  // While busy, load the output register whenever it is empty or being taken
  assign advance = busy_r && (!ovalid_r || out_ready);

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = reply_at(cnt_r, snap_mac_r, snap_ip_r, cfg.local_mac, cfg.gateway_ip);
      olast_nxt  = (cnt_r == POS_LAST_REQ);
      cnt_nxt    = cnt_r + 6'd1;
      if (cnt_r == POS_LAST_REQ) busy_nxt = 1'b0;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    // Start a new reply; the parser only fires while idle
    if (trig.valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Hold requester addresses for the whole reply
  always_ff @(posedge clk) begin
    if (trig.valid) begin
      snap_mac_r <= trig.requester_mac;
      snap_ip_r  <= trig.requester_ip;
    end
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

endmodule

`default_nettype wire

/* rtl/arp_gateway_request_responder.sv */
// Top level: answers ARP requests for the gateway IP with the local MAC.
// Throughput: one request byte per cycle; reply bytes stream out one per cycle while taken.
// Reply start: the last accepted request byte sets the busy flag, then the output register
//   takes the first reply byte, and the 42-byte reply follows with no gaps while ready.
// The input stalls only when a frame reaches its 42nd byte while the previous reply is
//   still being sent; it resumes once that reply's last byte is loaded.
// Reset (synchronous, rst_n low): control state cleared, responder off, parser rearmed.
`timescale 1ns / 1ps
`default_nettype none

module arp_gateway_request_responder
  import arpg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  arpg_rx_if.sink     in_if,
  arpg_tx_if.source   out_if,
  arpg_cfg_if.sink    cfg_if
);

  arpg_cfg_t  cfg;
  arpg_trig_t trig;
  logic       near_end;
  logic       busy;
  logic       in_accept;

  // Configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  arpg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  // Stall only a request that could launch a second reply
  assign in_if.ready = !(busy && near_end);
  assign in_accept   = in_if.valid && in_if.ready;

  arpg_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .rx_byte  (in_if.rx_byte),
    .rx_last  (in_if.rx_last),
    .cfg      (cfg),
    .near_end (near_end),
    .trig     (trig)
  );

  arpg_reply_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .trig      (trig),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_byte  (out_if.reply_byte),
    .out_last  (out_if.reply_last)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the ARP gateway request responder: table-driven and random frames.
`timescale 1ns / 1ps

module testbench;
  import arpg_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LATENCY_PAUSE = 4;
  localparam int IDLE_PCT      = 8;
  localparam int NO_FAULT      = -1;
  localparam int MAX_REPORTS   = 10;
  localparam int HDR_BYTES     = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // ARP request header, ethertype through opcode, as it appears on the wire
  localparam logic [8*HDR_BYTES-1:0] ARP_REQ_HDR = 80'h0806_0001_0800_0604_0001;

  typedef enum logic {OUTCOME_MODEL, OUTCOME_NONE} row_outcome_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  typedef struct {
    bit           write_cfg;
    bit           en;
    logic [47:0]  mac;
    logic [31:0]  gw;
    int           len;
    int           bad_pos;
    logic [47:0]  sha;
    logic [31:0]  spa;
    row_outcome_e outcome;
  } probe_row_t;

  logic clk;
  logic rst_n;

  arpg_rx_if  in_if();
  arpg_tx_if  out_if();
  arpg_cfg_if cfg_if();

  arp_gateway_request_responder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Shadow of the configuration and of the request parser
  logic        cfg_en;
  logic [47:0] cfg_mac;
  logic [31:0] cfg_gw;
  int          rx_pos;
  bit          rx_hdr_ok;
  logic [47:0] req_mac;
  logic [31:0] req_ip;

  reply_beat_t pending_replies[$];
  reply_beat_t seen_beat;
  reply_beat_t due_beat;
  logic [7:0]  frame_bytes[$];
  probe_row_t  probe_table[15];
  int          replies_predicted;
  int          bytes_sent;
  int          mismatch_count;
  logic        rx_hush;
  bit          steady_in;
  bit          steady_out;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Advance the parser shadow by one request byte; return one when a reply is due
  function automatic bit absorb_rx_byte(input logic [7:0] b, input logic last);
    bit due;
    int idx;
    due = 1'b0;
    if (rx_pos < FRAME_LEN) begin
      if (rx_pos >= POS_HDR_START && rx_pos < POS_SHA_START) begin
        idx = rx_pos - int'(POS_HDR_START);
        if (b != ARP_REQ_HDR[(HDR_BYTES - 1 - idx)*8 +: 8]) rx_hdr_ok = 1'b0;
      end else if (rx_pos >= POS_SHA_START && rx_pos < POS_SPA_START) begin
        req_mac = {req_mac[39:0], b};
      end else if (rx_pos >= POS_SPA_START && rx_pos < POS_THA_START) begin
        req_ip = {req_ip[23:0], b};
      end else if (rx_pos >= POS_TPA_START) begin
        idx = rx_pos - int'(POS_TPA_START);
        if (b != cfg_gw[(3 - idx)*8 +: 8]) rx_hdr_ok = 1'b0;
      end
      rx_pos++;
    end
    if (last) begin
      due = (rx_pos >= FRAME_LEN) && rx_hdr_ok && cfg_en;
      rx_pos = 0;
      rx_hdr_ok = 1'b1;
    end
    return due;
  endfunction

  // Queue the 42 reply bytes that answer the request just closed
  function automatic void queue_reply();
    logic [FRAME_LEN*8-1:0] img;
    img = {req_mac, cfg_mac, ARP_REQ_HDR[8*HDR_BYTES-1:8], OPCODE_REPLY,
           cfg_mac, cfg_gw, req_mac, req_ip};
    for (int k = 0; k < FRAME_LEN; k++) begin
      pending_replies.push_back('{img[(FRAME_LEN - 1 - k)*8 +: 8], k == FRAME_LEN - 1});
    end
    replies_predicted++;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  // Check reply bytes, track configuration writes and predict from request bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid === 1'b1 && out_if.ready) begin
        seen_beat = '{out_if.reply_byte, out_if.reply_last};
        if (pending_replies.size() == 0) begin
          flag_mismatch($sformatf("reply byte %h last %b with nothing pending",
                                  seen_beat.data, seen_beat.last));
        end else begin
          due_beat = pending_replies.pop_front();
          if (seen_beat.data !== due_beat.data) begin
            flag_mismatch($sformatf("reply_byte expected %h got %h",
                                    due_beat.data, seen_beat.data));
          end
          if (seen_beat.last !== due_beat.last) begin
            flag_mismatch($sformatf("reply_last expected %b got %b",
                                    due_beat.last, seen_beat.last));
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready === 1'b1) begin
        case (cfg_if.index)
          REG_RESPONDER_ENABLE: begin
            cfg_en = cfg_if.data[0];
          end
          REG_LOCAL_MAC: begin
            cfg_mac = cfg_if.data;
          end
          REG_GATEWAY_IP: begin
            cfg_gw = cfg_if.data[31:0];
          end
          default: begin
          end
        endcase
      end
      if (in_if.valid && in_if.ready === 1'b1) begin
        if (absorb_rx_byte(in_if.rx_byte, in_if.rx_last) && !rx_hush) queue_reply();
      end
    end
  end

  // Stall the reply side at random, except during steady stretches
  always @(negedge clk) begin
    out_if.ready <= steady_out || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offer one request byte and hold it until taken
  task automatic send_rx(input logic [7:0] b, input logic last, input logic hush);
    @(negedge clk);
    if (!steady_in) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    in_if.rx_last <= last;
    rx_hush       <= hush;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic rx_stop();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic hold_for_replies();
    rx_stop();
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic quiesce();
    hold_for_replies();
    repeat (LATENCY_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  // Write all registers while idle; junk fills bits that the registers drop
  task automatic write_settings(input bit en, input logic [47:0] mac, input logic [31:0] gw,
                                input logic [47:0] junk, input bit spare);
    quiesce();
    write_reg(REG_RESPONDER_ENABLE, {junk[47:1], en});
    write_reg(REG_LOCAL_MAC, mac);
    write_reg(REG_GATEWAY_IP, {junk[47:32], gw});
    if (spare) write_reg(REG_SPARE, junk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Lay out an ARP request to the current gateway, then pad, cut or corrupt it
  function automatic void build_frame(input int len, input int bad_pos,
                                      input logic [47:0] sha, input logic [31:0] spa);
    logic [FRAME_LEN*8-1:0] img;
    img = {48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}), ARP_REQ_HDR,
           sha, spa, 48'({$urandom(), $urandom()}), cfg_gw};
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      if (i < FRAME_LEN) frame_bytes.push_back(img[(FRAME_LEN - 1 - i)*8 +: 8]);
      else frame_bytes.push_back(8'($urandom()));
    end
    if (bad_pos >= 0 && bad_pos < len) begin
      frame_bytes[bad_pos] = frame_bytes[bad_pos] ^ 8'($urandom_range(255, 1));
    end
  endfunction

  task automatic send_frame(input int len, input int bad_pos, input logic [47:0] sha,
                            input logic [31:0] spa, input bit noise, input logic hush);
    build_frame(len, bad_pos, sha, spa);
    for (int i = 0; i < len; i++) begin
      send_rx(noise ? 8'($urandom()) : frame_bytes[i], i == len - 1, hush);
    end
  endtask

  // Mostly well-formed requests, the rest short, corrupted or plain noise
  task automatic send_random_frame();
    int pick;
    int len;
    int bad_pos;
    bit noise;
    pick    = $urandom_range(99);
    len     = FRAME_LEN;
    bad_pos = NO_FAULT;
    noise   = 1'b0;
    if (pick < 65) begin
      // pad some requests well past the point where the count saturates
      if ($urandom_range(3) == 0) len = $urandom_range(90, 43);
    end else if (pick < 77) begin
      len = $urandom_range(41, 1);
    end else if (pick < 90) begin
      bad_pos = $urandom_range(1) ? $urandom_range(21, 12) : $urandom_range(41, 38);
    end else begin
      len   = $urandom_range(90, 1);
      noise = 1'b1;
    end
    send_frame(len, bad_pos, 48'({$urandom(), $urandom()}), $urandom(), noise, 1'b0);
    // hold off now and then until every reply is out
    if ($urandom_range(5) == 0) hold_for_replies();
  endtask

  initial begin : stimulus
    bit          en;
    logic [47:0] mac;
    logic [31:0] gw;
    logic [47:0] junk;
    int          start_bytes;
    int          start_replies;

    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    in_if.rx_last = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_RESPONDER_ENABLE;
    cfg_if.data   = 48'h0;
    out_if.ready  = 1'b0;
    rx_hush       = 1'b0;
    steady_in     = 1'b0;
    steady_out    = 1'b0;
    cfg_en        = 1'b0;
    cfg_mac       = 48'h0;
    cfg_gw        = 32'h0;
    rx_pos        = 0;
    rx_hdr_ok     = 1'b1;
    req_mac       = 48'h0;
    req_ip        = 32'h0;
    replies_predicted = 0;
    bytes_sent        = 0;
    mismatch_count    = 0;

    // cfg, en, mac, gw, length, corrupted byte, sender mac, sender ip, outcome
    probe_table = '{
      '{0, 0, 48'h0, 32'h0, 42, NO_FAULT, 48'h0012_3456_789a, 32'h0a00_0001, OUTCOME_NONE},
      '{1, 1, 48'h02aa_bbcc_ddee, 32'hc0a8_0001, 42, NO_FAULT,
        48'hffff_ffff_ffff, 32'hffff_ffff, OUTCOME_MODEL},
      '{0, 0, 48'h0, 32'h0, 42, NO_FAULT, 48'h0, 32'h0, OUTCOME_MODEL},
      '{0, 0, 48'h0, 32'h0, 41, NO_FAULT, 48'h0a0b_0c0d_0e0f, 32'h0a01_0203, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 1, NO_FAULT, 48'h0a0b_0c0d_0e0f, 32'h0a01_0203, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 70, NO_FAULT, 48'h5a5a_a5a5_5a5a, 32'ha5a5_5a5a, OUTCOME_MODEL},
      '{0, 0, 48'h0, 32'h0, 42, 12, 48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 42, 14, 48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 42, 18, 48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 42, 21, 48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 42, 38, 48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{0, 0, 48'h0, 32'h0, 42, 41, 48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{1, 0, 48'h02aa_bbcc_ddee, 32'hc0a8_0001, 42, NO_FAULT,
        48'h1111_2222_3333, 32'h0101_0101, OUTCOME_NONE},
      '{1, 1, 48'hffff_ffff_ffff, 32'hffff_ffff, 42, NO_FAULT,
        48'h8000_0000_0001, 32'h8000_0001, OUTCOME_MODEL},
      '{1, 1, 48'h0, 32'h0, 43, NO_FAULT, 48'h7fff_ffff_fffe, 32'h7fff_fffe, OUTCOME_MODEL}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (probe_table[r]) begin
      if (probe_table[r].write_cfg) begin
        write_settings(probe_table[r].en, probe_table[r].mac, probe_table[r].gw, 48'h0, 1'b0);
      end
      send_frame(probe_table[r].len, probe_table[r].bad_pos, probe_table[r].sha,
                 probe_table[r].spa, 1'b0, probe_table[r].outcome == OUTCOME_NONE);
    end

    // Random frames under several settings; the second runs without any idling
    for (int ph = 0; ph < 5; ph++) begin
      junk = 48'({$urandom(), $urandom()});
      case (ph)
        0: begin
          en  = 1'b1;
          mac = 48'({$urandom(), $urandom()});
          gw  = $urandom();
        end
        1: begin
          en   = 1'b1;
          mac  = '1;
          gw   = '1;
          junk = 48'h0;
        end
        2: begin
          en  = 1'b1;
          mac = 48'h0;
          gw  = 32'h0;
        end
        3: begin
          en  = 1'b0;
          mac = 48'({$urandom(), $urandom()});
          gw  = $urandom();
        end
        default: begin
          en  = 1'b1;
          mac = 48'({$urandom(), $urandom()});
          gw  = $urandom();
        end
      endcase
      write_settings(en, mac, gw, junk, ph == 3);
      steady_in     = (ph == 1);
      steady_out    = (ph == 1);
      start_bytes   = bytes_sent;
      start_replies = replies_predicted;
      while (bytes_sent - start_bytes < 40 || (en && replies_predicted - start_replies < 2)) begin
        send_random_frame();
      end
    end

    // Drain and let the block settle
    hold_for_replies();
    repeat (2 * LATENCY_PAUSE) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("arp_gateway_request_responder verification clean");
    end else begin
      $display("arp_gateway_request_responder verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("arp_gateway_request_responder verification failed");
    $finish;
  end

endmodule
